/* hdl/sbda_pkg.sv */
// Shared constants and helpers for the signed binary to decimal ASCII core.
// No dependencies; imported by the front queue, the back converter and the top level.
package sbda_pkg;

  // ASCII codes that the core emits
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Binary bits folded into the BCD register per converter cycle
  localparam int BITS_PER_STEP = 4;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Decimal digits needed for the largest magnitude, 2**(bits-1)
  function automatic int dec_digits(input int bits);
    longint unsigned v;
    int              n;
    v = 64'd1 << (bits - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        n = n + 1;
        v = v / 10;
      end
    end
    return n;
  endfunction

endpackage

/* hdl/sbda_in_if.sv */
// Input channel: one signed binary value per transfer.
// Valid/ready handshake; width follows the core's VALUE_BITS parameter.
interface sbda_in_if #(
  parameter int VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* hdl/sbda_out_if.sv */
// Result channel: one ASCII character per transfer, last marks the end of a number.
// Valid/ready handshake; no dependencies.
interface sbda_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* hdl/sbda_front.sv */
// Front end: accepts values, splits off the sign, forms the unsigned magnitude
// and buffers the result in a short queue. Depends on sbda_pkg and sbda_in_if.
module sbda_front
  import sbda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sbda_in_if.sink               in_ch,
  output logic                  q_valid,
  output logic                  q_neg,
  output logic [VALUE_BITS-1:0] q_mag,
  input  logic                  q_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS:0] q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                push;
  logic                pop;
  logic                neg;
  logic [VALUE_BITS-1:0] mag;

  // Classify: sign bit and two's complement magnitude, taken as unsigned
  assign neg = in_ch.value[VALUE_BITS-1];
  assign mag = neg ? (~in_ch.value + 1'b1) : in_ch.value;

  assign in_ch.ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_valid && q_ready;

  assign q_neg = q_mem_r[rd_ptr_r][VALUE_BITS];
  assign q_mag = q_mem_r[rd_ptr_r][VALUE_BITS-1:0];

  // Store classified item
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= {neg, mag};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Occupancy never exceeds the queue depth
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy overflow");

  // A pop with one entry and no push leaves the queue empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && count_r == CNT_W'(1)) |=> !q_valid)
    else $error("queue not empty after last pop");

  // A push into an empty queue makes data available next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && count_r == '0) |=> q_valid)
    else $error("pushed item not visible");

endmodule

/* hdl/sbda_back.sv */
// Back end: converts the magnitude to BCD by shift-and-add-3, four bits a cycle,
// then streams the sign and digits as ASCII. Depends on sbda_pkg and sbda_out_if.
module sbda_back
  import sbda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic                  q_neg,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  q_ready,
  sbda_out_if.source            out_ch
);

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int NSTEP = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W = NSTEP * BITS_PER_STEP;
  localparam int CNT_W = $clog2(NSTEP + 1);
  localparam int IDX_W = $clog2(NDIG);

  // Converter registers
  logic                 cv_busy_r;
  logic [CNT_W-1:0]     cv_cnt_r;
  logic [PAD_W-1:0]     cv_mag_r;
  logic [NDIG-1:0][3:0] cv_bcd_r;
  logic                 cv_neg_r;
  logic                 cv_done;
  logic                 cv_load;
  logic [NDIG-1:0][3:0] cv_bcd_step;

  // Emitter registers
  logic                 em_busy_r, em_busy_nxt;
  logic                 em_sign_r, em_sign_nxt;
  logic [IDX_W-1:0]     em_pos_r,  em_pos_nxt;
  logic [NDIG-1:0][3:0] em_bcd_r;
  logic [3:0]           em_digit;
  logic                 em_xfer;
  logic                 em_finish;
  logic                 em_load;
  logic [IDX_W-1:0]     lead_idx;

  assign cv_done = cv_busy_r && (cv_cnt_r == '0);

  // Hand off a finished conversion when the emitter is free or frees up now
  assign em_xfer   = out_ch.valid && out_ch.ready;
  assign em_finish = em_xfer && !em_sign_r && (em_pos_r == '0);
  assign em_load   = cv_done && (!em_busy_r || em_finish);

  assign q_ready = !cv_busy_r || em_load;
  assign cv_load = q_valid && q_ready;

  // Fold the next four magnitude bits into the BCD digits
  always_comb begin
    cv_bcd_step = cv_bcd_r;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (cv_bcd_step[d] >= 4'd5) begin
          cv_bcd_step[d] = cv_bcd_step[d] + 4'd3;
        end
      end
      cv_bcd_step = {cv_bcd_step[NDIG-1][2:0], cv_bcd_step[NDIG-2:0],
                     cv_mag_r[PAD_W-1-j]};
    end
  end

  // Converter control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_busy_r <= 1'b0;
      cv_cnt_r  <= '0;
    end else if (cv_load) begin
      cv_busy_r <= 1'b1;
      cv_cnt_r  <= CNT_W'(NSTEP);
    end else if (em_load) begin
      cv_busy_r <= 1'b0;
    end else if (cv_busy_r && cv_cnt_r != '0) begin
      cv_cnt_r <= cv_cnt_r - 1'b1;
    end
  end

  // Converter datapath
  always_ff @(posedge clk) begin
    if (cv_load) begin
      cv_mag_r <= PAD_W'(q_mag);
      cv_bcd_r <= '0;
      cv_neg_r <= q_neg;
    end else if (cv_busy_r && cv_cnt_r != '0) begin
      cv_mag_r <= {cv_mag_r[PAD_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
      cv_bcd_r <= cv_bcd_step;
    end
  end

  // Find the most significant nonzero digit; zero maps to digit 0
  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (cv_bcd_r[d] != 4'd0) begin
        lead_idx = IDX_W'(d);
      end
    end
  end

  // Emitter next state
  always_comb begin
    em_busy_nxt = em_busy_r;
    em_sign_nxt = em_sign_r;
    em_pos_nxt  = em_pos_r;
    if (em_load) begin
      em_busy_nxt = 1'b1;
      em_sign_nxt = cv_neg_r;
      em_pos_nxt  = lead_idx;
    end else if (em_xfer) begin
      if (em_sign_r) begin
        em_sign_nxt = 1'b0;
      end else if (em_pos_r == '0) begin
        em_busy_nxt = 1'b0;
      end else begin
        em_pos_nxt = em_pos_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r <= 1'b0;
      em_sign_r <= 1'b0;
      em_pos_r  <= '0;
    end else begin
      em_busy_r <= em_busy_nxt;
      em_sign_r <= em_sign_nxt;
      em_pos_r  <= em_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (em_load) begin
      em_bcd_r <= cv_bcd_r;
    end
  end

  // Drive the character from the held digits
  assign em_digit         = em_bcd_r[em_pos_r];
  assign out_ch.valid     = em_busy_r;
  assign out_ch.char_code = em_sign_r ? CHAR_MINUS : (CHAR_ZERO + {4'd0, em_digit});
  assign out_ch.last      = !em_sign_r && (em_pos_r == '0);

  // A pending sign only exists while a number is being sent
  assert property (@(posedge clk) disable iff (!rst_n)
    em_sign_r |-> em_busy_r)
    else $error("sign pending with idle emitter");

  // Every digit sent is a decimal digit
  assert property (@(posedge clk) disable iff (!rst_n)
    (em_busy_r && !em_sign_r) |-> (em_digit <= 4'd9))
    else $error("non-decimal digit emitted");

  // No leading zero after a load unless the number is a single digit
  assert property (@(posedge clk) disable iff (!rst_n)
    em_load |=> (em_pos_r == '0 || em_digit != 4'd0))
    else $error("leading zero selected");

  // Step counter stays within the conversion length
  assert property (@(posedge clk) disable iff (!rst_n)
    cv_cnt_r <= CNT_W'(NSTEP))
    else $error("converter step count out of range");

endmodule

/* hdl/signed_binary_to_decimal_ascii_core.sv */
// Path: an accepted value passes the front queue, the BCD converter and the emitter registers
// before its first character is valid. Throughput: one character per cycle while out_ch.ready
// is high; the next number converts while the last one streams, so the pace per number is set
// by the four-bit-per-cycle BCD converter and the single output character per transfer.
// Reset (rst_n, synchronous, active low) clears queue, converter and emitter control.
module signed_binary_to_decimal_ascii_core
  import sbda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sbda_in_if.sink    in_ch,
  sbda_out_if.source out_ch
);

  logic                  q_valid;
  logic                  q_ready;
  logic                  q_neg;
  logic [VALUE_BITS-1:0] q_mag;

  // Classify and queue
  sbda_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .q_ready (q_ready)
  );

  // Convert and stream characters
  sbda_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

  // Each character is a minus sign or a decimal digit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.char_code == CHAR_MINUS ||
                      (out_ch.char_code >= CHAR_ZERO && out_ch.char_code <= CHAR_ZERO + 8'd9)))
    else $error("illegal character on output");

  // A minus sign is never the last character of a number
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.char_code == CHAR_MINUS) |-> !out_ch.last)
    else $error("number ends in a sign");

  // A transferred minus sign is followed by a digit that is not zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.char_code == CHAR_MINUS)
      |=> (out_ch.valid && out_ch.char_code != CHAR_ZERO))
    else $error("sign not followed by leading digit");

endmodule
